>>> rtl/core/binary_to_decimal_ascii_unit_defines.svh
// Assertion macros for the binary to decimal ASCII unit.
// Expects clk and rst_n in the scope of each use.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`ifndef SYNTH
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg)
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/b2da_pkg.sv
// Shared types, character codes and place-value tables for the decimal text unit.
// No dependencies.
`timescale 1ns / 1ps
package b2da_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam int         N_PLACES   = 9;
  localparam logic [3:0] UNITS_IDX  = 4'(N_PLACES);

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } b2da_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b2da_q_stat_t;

  // k times the place value selected by idx, wide enough for 9 * 10^9
  function automatic logic [35:0] pv_mult(input logic [3:0] idx, input int k);
    logic [35:0] pv;
    unique case (idx)
      4'd0:    pv = 36'd1000000000;
      4'd1:    pv = 36'd100000000;
      4'd2:    pv = 36'd10000000;
      4'd3:    pv = 36'd1000000;
      4'd4:    pv = 36'd100000;
      4'd5:    pv = 36'd10000;
      4'd6:    pv = 36'd1000;
      4'd7:    pv = 36'd100;
      4'd8:    pv = 36'd10;
      default: pv = 36'd0;
    endcase
    return 36'(pv * 36'(k));
  endfunction

endpackage

>>> rtl/core/b2da_front.sv
// Front end: classifies each request into sign flag and magnitude.
// Depends on b2da_pkg.
`timescale 1ns / 1ps
module b2da_front import b2da_pkg::*; (
  input  logic [31:0] value,
  input  logic        signed_mode,
  output b2da_item_t  item
);

  logic neg;

  always_comb begin
    neg      = signed_mode & value[31];
    item.neg = neg;
    // two's complement negate; the most negative word maps onto itself
    item.mag = neg ? (~value + 32'd1) : value;
  end

endmodule

>>> rtl/core/b2da_fifo.sv
// Short request queue between the front end and the digit engine.
// Depends on b2da_pkg.
`timescale 1ns / 1ps
module b2da_fifo import b2da_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  b2da_item_t   wr_item,
  input  logic         pop,
  output b2da_item_t   rd_item,
  output b2da_q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b2da_item_t    mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
  endfunction

  always_comb begin
    wp_nxt  = push ? bump(wp_r) : wp_r;
    rp_nxt  = pop ? bump(rp_r) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
    stat.full  = (cnt_r == CW'(DEPTH));
    stat.empty = (cnt_r == '0);
    rd_item    = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

>>> rtl/core/b2da_back.sv
// Digit engine: one place value per cycle, emits sign, digits and units digit.
// Depends on b2da_pkg.
`timescale 1ns / 1ps
module b2da_back import b2da_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  b2da_item_t   rd_item,
  input  b2da_q_stat_t stat,
  output logic         pop,
  output logic         out_valid,
  output logic [7:0]   out_character,
  output logic         out_last
);

  logic        act_r, act_nxt;
  logic        neg_r, neg_nxt;
  logic        started_r, started_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  char_r, char_nxt;
  logic        last_r, last_nxt;

  logic [35:0] mult [10];
  logic [3:0]  digit;
  logic [31:0] rem;
  logic        at_units, fin;

  always_comb begin
    for (int k = 0; k < 10; k++) begin
      mult[k] = pv_mult(idx_r, k);
    end
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, mag_r} >= mult[k]) begin
        digit = 4'(k);
      end
    end
    rem = mag_r - mult[digit][31:0];

    at_units = (idx_r == UNITS_IDX);
    fin      = act_r && !neg_r && at_units;
    pop      = (!act_r || fin) && !stat.empty;

    act_nxt     = act_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    mag_nxt     = mag_r;
    idx_nxt     = idx_r;
    if (pop) begin
      act_nxt     = 1'b1;
      neg_nxt     = rd_item.neg;
      mag_nxt     = rd_item.mag;
      idx_nxt     = 4'd0;
      started_nxt = 1'b0;
    end else if (act_r) begin
      if (neg_r) begin
        neg_nxt = 1'b0;
      end else if (!at_units) begin
        mag_nxt     = rem;
        idx_nxt     = idx_r + 4'd1;
        started_nxt = started_r | (digit != 4'd0);
      end else begin
        act_nxt = 1'b0;
      end
    end

    // drop leading zeros; the units digit always goes out
    valid_nxt = act_r && (neg_r || at_units || started_r || (digit != 4'd0));
    last_nxt  = !neg_r && at_units;
    if (neg_r) begin
      char_nxt = CHAR_MINUS;
    end else if (at_units) begin
      char_nxt = CHAR_ZERO + {4'd0, mag_r[3:0]};
    end else begin
      char_nxt = CHAR_ZERO + {4'd0, digit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r     <= neg_nxt;
    started_r <= started_nxt;
    mag_r     <= mag_nxt;
    idx_r     <= idx_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last      = last_r;

endmodule

>>> rtl/core/binary_to_decimal_ascii_unit.sv
// Binary word to decimal ASCII text, one character per out_valid strobe.
// Outputs are registered: an optional '-' for a negative signed word, then the digits from
// the 10^9 place down to the units digit; suppressed leading zeros leave gaps. The engine
// takes the place values in turn and pops the next word as the units digit is formed; the
// request queue takes start meanwhile. Reset (rst_n low) empties it, idles the engine.
// The receiver cannot stall; each character is valid for exactly one cycle.
`timescale 1ns / 1ps
`include "binary_to_decimal_ascii_unit_defines.svh"
module binary_to_decimal_ascii_unit import b2da_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_value,
  input  logic        in_signed_mode,
  output logic        out_valid,
  output logic [7:0]  out_character,
  output logic        out_last
);

  b2da_item_t   wr_item, rd_item;
  b2da_q_stat_t stat;
  logic         push, pop;

  assign busy = stat.full;
  assign push = start && !busy;

  b2da_front u_front (
    .value       (in_value),
    .signed_mode (in_signed_mode),
    .item        (wr_item)
  );

  b2da_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .stat    (stat)
  );

  b2da_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_item       (rd_item),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  `B2DA_ASSERT_IMP(a_minus_not_last, out_valid && out_character == CHAR_MINUS, !out_last, "sign marked last")
  `B2DA_ASSERT_NXT(a_digits_contiguous, out_valid && !out_last && out_character != CHAR_MINUS, out_valid, "gap inside digit run")
  `B2DA_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")

endmodule
